[rtl/tpr_pkg.sv]
package tpr_pkg;

  // Sign and magnitude number, magnitude in Q32.32.
  typedef struct packed {
    logic        neg;
    logic [63:0] mag;
  } rnum_t;

  typedef struct packed {
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
  } in_t;

  typedef struct packed {
    logic signed [15:0] source_x;
    logic signed [15:0] source_y;
    logic               clipped;
  } out_t;

  typedef enum logic [2:0] {
    REG_COS_TILT,
    REG_SIN_TILT,
    REG_FOCAL_LENGTH,
    REG_MOUNT_HEIGHT,
    REG_SENSOR_WIDTH,
    REG_SENSOR_HEIGHT,
    REG_IMAGE_WIDTH,
    REG_IMAGE_HEIGHT
  } cfg_reg_t;

  localparam int CFG_W = 48;

  localparam logic [31:0] COS_TILT_RST      = 32'h4000_0000;
  localparam logic [31:0] SIN_TILT_RST      = 32'h0000_0000;
  localparam logic [47:0] FOCAL_LENGTH_RST  = 48'd11520133;
  localparam logic [47:0] MOUNT_HEIGHT_RST  = 48'h0190_0000_0000;
  localparam logic [47:0] SENSOR_WIDTH_RST  = 48'd17280200;
  localparam logic [47:0] SENSOR_HEIGHT_RST = 48'd9720113;
  localparam logic [12:0] IMAGE_WIDTH_RST   = 13'd1920;
  localparam logic [12:0] IMAGE_HEIGHT_RST  = 13'd1080;

  // Fixed latencies of the arithmetic units.
  localparam int MUL_LAT = 2;
  localparam int DIV_LAT = 65;

  // Values that follow from the configuration alone.
  typedef struct packed {
    rnum_t hc;
    rnum_t a;
    rnum_t yrmin;
    rnum_t xrmin;
    rnum_t ystep;
    rnum_t xstep;
    rnum_t fwi;
    logic  sat;
    logic  zero;
  } derived_t;

  typedef enum logic [1:0] {
    SU_IDLE,
    SU_ISSUE,
    SU_WAIT
  } su_state_t;

  typedef enum logic [3:0] {
    ST_HC,
    ST_A,
    ST_SHS,
    ST_NUM0,
    ST_YRMAX,
    ST_YRMIN,
    ST_SYR,
    ST_ZWS,
    ST_XR,
    ST_YSTEP,
    ST_XSTEP,
    ST_FWI
  } su_step_t;

  function automatic rnum_t mk(input logic neg, input logic [63:0] mag);
    rnum_t r;
    r.neg = neg && (mag != 64'd0);
    r.mag = mag;
    return r;
  endfunction

  function automatic rnum_t rneg(input rnum_t a);
    return mk(!a.neg, a.mag);
  endfunction

  function automatic rnum_t rhalf(input rnum_t a);
    return mk(a.neg, {1'b0, a.mag[63:1]});
  endfunction

  function automatic rnum_t radd(input rnum_t a, input rnum_t b);
    logic [64:0] s;
    s = {1'b0, a.mag} + {1'b0, b.mag};
    if (a.neg == b.neg) begin
      return mk(a.neg, s[64] ? {64{1'b1}} : s[63:0]);
    end else if (a.mag >= b.mag) begin
      return mk(a.neg, a.mag - b.mag);
    end else begin
      return mk(b.neg, b.mag - a.mag);
    end
  endfunction

  function automatic logic radd_sat(input rnum_t a, input rnum_t b);
    logic [64:0] s;
    s = {1'b0, a.mag} + {1'b0, b.mag};
    return (a.neg == b.neg) && s[64];
  endfunction

  function automatic rnum_t from_trig(input logic [31:0] v);
    logic [31:0] m;
    m = v[31] ? (~v + 32'd1) : v;
    return mk(v[31], {30'd0, m, 2'b00});
  endfunction

  function automatic rnum_t from_int13(input logic [12:0] n);
    return mk(1'b0, {19'd0, n, 32'd0});
  endfunction

  function automatic rnum_t from_int12(input logic [11:0] n);
    return mk(1'b0, {20'd0, n, 32'd0});
  endfunction

  function automatic logic [15:0] to_out_val(input rnum_t v);
    logic [31:0] ip;
    logic [16:0] t;
    ip = v.mag[63:32];
    if (v.neg) begin
      if (ip > 32'd32768) ip = 32'd32768;
      t = 17'h10000 - ip[16:0];
      return t[15:0];
    end
    if (ip > 32'd32767) ip = 32'd32767;
    return ip[15:0];
  endfunction

  function automatic logic to_out_sat(input rnum_t v);
    logic [31:0] ip;
    ip = v.mag[63:32];
    return v.neg ? (ip > 32'd32768) : (ip > 32'd32767);
  endfunction

endpackage

[rtl/tpr_mul.sv]
module tpr_mul
  import tpr_pkg::*;
#(
  parameter int SB_W = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            vin,
  input  rnum_t           a,
  input  rnum_t           b,
  input  logic [SB_W-1:0] sbin,
  output logic            vout,
  output rnum_t           p,
  output logic            sat,
  output logic [SB_W-1:0] sbout
);

  logic [63:0]     ll_r, lh_r, hl_r, hh_r;
  logic            neg1_r, v1_r, v2_r, sat_r;
  logic [SB_W-1:0] sb1_r, sb2_r;
  rnum_t           p_r;

  logic [33:0] mid;
  logic [65:0] hi;
  logic        sat_nxt;
  rnum_t       p_nxt;

  always_comb begin
    mid = {2'b00, ll_r[63:32]} + {2'b00, lh_r[31:0]} + {2'b00, hl_r[31:0]};
    hi  = {2'b00, hh_r} + {34'd0, lh_r[63:32]} + {34'd0, hl_r[63:32]}
        + {64'd0, mid[33:32]};
    sat_nxt = (hi[65:32] != 34'd0);
    p_nxt   = mk(neg1_r, sat_nxt ? {64{1'b1}} : {hi[31:0], mid[31:0]});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= vin;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ll_r   <= a.mag[31:0]  * b.mag[31:0];
      lh_r   <= a.mag[31:0]  * b.mag[63:32];
      hl_r   <= a.mag[63:32] * b.mag[31:0];
      hh_r   <= a.mag[63:32] * b.mag[63:32];
      neg1_r <= a.neg ^ b.neg;
      sb1_r  <= sbin;
      p_r    <= p_nxt;
      sat_r  <= sat_nxt;
      sb2_r  <= sb1_r;
    end
  end

  assign vout  = v2_r;
  assign p     = p_r;
  assign sat   = sat_r;
  assign sbout = sb2_r;

endmodule

[rtl/tpr_div.sv]
module tpr_div
  import tpr_pkg::*;
#(
  parameter int SB_W = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            vin,
  input  rnum_t           a,
  input  rnum_t           b,
  input  logic [SB_W-1:0] sbin,
  output logic            vout,
  output rnum_t           q,
  output logic            sat,
  output logic            zero,
  output logic [SB_W-1:0] sbout
);

  // One quotient bit per stage after a setup stage.
  logic [63:0]     rem_r  [0:64];
  logic [63:0]     quo_r  [0:64];
  logic [31:0]     low_r  [0:64];
  logic [63:0]     dvs_r  [0:64];
  logic            neg_r  [0:64];
  logic            sat_r  [0:64];
  logic            zero_r [0:64];
  logic [SB_W-1:0] sb_r   [0:64];
  logic            v_r    [0:64];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= {32'd0, a.mag[63:32]};
      low_r[0]  <= a.mag[31:0];
      quo_r[0]  <= 64'd0;
      dvs_r[0]  <= b.mag;
      neg_r[0]  <= a.neg ^ b.neg;
      zero_r[0] <= (b.mag == 64'd0);
      sat_r[0]  <= (b.mag != 64'd0) && ({32'd0, a.mag[63:32]} >= b.mag);
      sb_r[0]   <= sbin;
    end
  end

  for (genvar k = 1; k <= 64; k++) begin : g_stage
    logic        in_bit;
    logic [64:0] sh;
    logic [64:0] diff;
    logic        ge;

    if (k <= 32) begin : g_low
      assign in_bit = low_r[k-1][32-k];
    end else begin : g_zero
      assign in_bit = 1'b0;
    end

    assign sh   = {rem_r[k-1], in_bit};
    assign diff = sh - {1'b0, dvs_r[k-1]};
    assign ge   = (sh >= {1'b0, dvs_r[k-1]});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? diff[63:0] : sh[63:0];
        quo_r[k]  <= {quo_r[k-1][62:0], ge};
        low_r[k]  <= low_r[k-1];
        dvs_r[k]  <= dvs_r[k-1];
        neg_r[k]  <= neg_r[k-1];
        zero_r[k] <= zero_r[k-1];
        sat_r[k]  <= sat_r[k-1];
        sb_r[k]   <= sb_r[k-1];
      end
    end
  end

  assign vout  = v_r[64];
  assign q     = mk(neg_r[64], zero_r[64] ? 64'd0 :
                               sat_r[64]  ? {64{1'b1}} : quo_r[64]);
  assign sat   = sat_r[64];
  assign zero  = zero_r[64];
  assign sbout = sb_r[64];

endmodule

[rtl/tpr_setup.sv]
module tpr_setup
  import tpr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  rnum_t    c,
  input  rnum_t    s,
  input  rnum_t    f,
  input  rnum_t    h,
  input  rnum_t    ws,
  input  rnum_t    hs,
  input  rnum_t    wi,
  input  rnum_t    hi,
  output derived_t drv,
  output logic     busy
);

  su_state_t state_r, state_nxt;
  su_step_t  step_r, step_nxt;
  logic [6:0] cnt_r, cnt_nxt;

  rnum_t hc_r, a_r, shalf_r, num0_r, yrmax_r, yrmin_r, tmp_r;
  rnum_t xrmax_r, ystep_r, xstep_r, fwi_r;
  logic  sat_r, zero_r;

  logic  is_div, iss_mul, iss_div, take;
  rnum_t op_a, op_b;
  logic  op_sat;
  rnum_t mul_p, div_q, res;
  logic  mul_sat, div_sat, div_zero;

  rnum_t one_n, ap_n, am_n, zsub_n, xrmin_n, yspan_n, xspan_n, ysum_n, xsum_n;

  assign one_n   = mk(1'b0, 64'h0000_0001_0000_0000);
  assign ap_n    = radd(a_r, shalf_r);
  assign am_n    = radd(a_r, rneg(shalf_r));
  assign zsub_n  = radd(hc_r, rneg(tmp_r));
  assign xrmin_n = rneg(xrmax_r);
  assign yspan_n = radd(yrmax_r, rneg(yrmin_r));
  assign xspan_n = radd(xrmax_r, rneg(xrmin_n));
  assign ysum_n  = radd(yspan_n, one_n);
  assign xsum_n  = radd(xspan_n, one_n);

  always_comb begin
    unique case (step_r) inside
      ST_HC, ST_YRMAX, ST_YRMIN, ST_XR, ST_YSTEP, ST_XSTEP: is_div = 1'b1;
      default: is_div = 1'b0;
    endcase
  end

  always_comb begin
    op_a   = h;
    op_b   = c;
    op_sat = 1'b0;
    unique case (step_r)
      ST_HC: begin
        op_a = h;
        op_b = c;
      end
      ST_A: begin
        op_a = f;
        op_b = c;
      end
      ST_SHS: begin
        op_a = s;
        op_b = hs;
      end
      ST_NUM0: begin
        op_a = rhalf(hs);
        op_b = hc_r;
      end
      ST_YRMAX: begin
        op_a   = num0_r;
        op_b   = ap_n;
        op_sat = radd_sat(a_r, shalf_r);
      end
      ST_YRMIN: begin
        op_a   = num0_r;
        op_b   = am_n;
        op_sat = radd_sat(a_r, rneg(shalf_r));
      end
      ST_SYR: begin
        op_a = s;
        op_b = yrmin_r;
      end
      ST_ZWS: begin
        op_a   = zsub_n;
        op_b   = ws;
        op_sat = radd_sat(hc_r, rneg(tmp_r));
      end
      ST_XR: begin
        op_a = tmp_r;
        op_b = f;
      end
      ST_YSTEP: begin
        op_a   = ysum_n;
        op_b   = hi;
        op_sat = radd_sat(yrmax_r, rneg(yrmin_r)) | radd_sat(yspan_n, one_n);
      end
      ST_XSTEP: begin
        op_a   = xsum_n;
        op_b   = wi;
        op_sat = radd_sat(xrmax_r, rneg(xrmin_n)) | radd_sat(xspan_n, one_n);
      end
      ST_FWI: begin
        op_a = f;
        op_b = wi;
      end
      default: begin
        op_a = h;
        op_b = c;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cnt_nxt   = cnt_r;
    if (start) begin
      state_nxt = SU_ISSUE;
      step_nxt  = ST_HC;
    end else begin
      unique case (state_r)
        SU_IDLE: state_nxt = SU_IDLE;
        SU_ISSUE: begin
          state_nxt = SU_WAIT;
          cnt_nxt   = is_div ? 7'(DIV_LAT - 1) : 7'(MUL_LAT - 1);
        end
        SU_WAIT: begin
          if (cnt_r == 7'd0) begin
            if (step_r == ST_FWI) begin
              state_nxt = SU_IDLE;
            end else begin
              state_nxt = SU_ISSUE;
              step_nxt  = su_step_t'(4'(step_r) + 4'd1);
            end
          end else begin
            cnt_nxt = cnt_r - 7'd1;
          end
        end
        default: state_nxt = SU_IDLE;
      endcase
    end
  end

  // Outputs of the sequencer.
  always_comb begin
    busy    = 1'b1;
    iss_mul = 1'b0;
    iss_div = 1'b0;
    take    = 1'b0;
    unique case (state_r)
      SU_IDLE:  busy = 1'b0;
      SU_ISSUE: begin
        iss_mul = !is_div;
        iss_div = is_div;
      end
      SU_WAIT:  take = (cnt_r == 7'd0) && !start;
      default:  busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SU_ISSUE;
      step_r  <= ST_HC;
      cnt_r   <= 7'd0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  tpr_mul #(.SB_W(1)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (1'b1),
    .vin   (iss_mul),
    .a     (op_a),
    .b     (op_b),
    .sbin  (1'b0),
    .vout  (),
    .p     (mul_p),
    .sat   (mul_sat),
    .sbout ()
  );

  tpr_div #(.SB_W(1)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (1'b1),
    .vin   (iss_div),
    .a     (op_a),
    .b     (op_b),
    .sbin  (1'b0),
    .vout  (),
    .q     (div_q),
    .sat   (div_sat),
    .zero  (div_zero),
    .sbout ()
  );

  assign res = is_div ? div_q : mul_p;

  always_ff @(posedge clk) begin
    if (!rst_n || start) begin
      sat_r  <= 1'b0;
      zero_r <= 1'b0;
    end else if (take) begin
      sat_r  <= sat_r | op_sat | (is_div ? div_sat : mul_sat);
      zero_r <= zero_r | (is_div && div_zero);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      case (step_r)
        ST_HC:    hc_r    <= res;
        ST_A:     a_r     <= res;
        ST_SHS:   shalf_r <= rhalf(res);
        ST_NUM0:  num0_r  <= res;
        ST_YRMAX: yrmax_r <= res;
        ST_YRMIN: yrmin_r <= rneg(res);
        ST_SYR:   tmp_r   <= res;
        ST_ZWS:   tmp_r   <= res;
        ST_XR:    xrmax_r <= rhalf(res);
        ST_YSTEP: ystep_r <= res;
        ST_XSTEP: xstep_r <= res;
        ST_FWI:   fwi_r   <= res;
        default:  fwi_r   <= fwi_r;
      endcase
    end
  end

  always_comb begin
    drv.hc    = hc_r;
    drv.a     = a_r;
    drv.yrmin = yrmin_r;
    drv.xrmin = xrmin_n;
    drv.ystep = ystep_r;
    drv.xstep = xstep_r;
    drv.fwi   = fwi_r;
    drv.sat   = sat_r;
    drv.zero  = zero_r;
  end

endmodule

[rtl/tilt_perspective_remap_coords.sv]
// Coordinate generator for rectifying a tilted camera view.
// Input channel in_valid/in_ready/in_data carries one output pixel
// (pixel_x, pixel_y); the result channel out_valid/out_ready/out_data
// returns the source coordinate to sample and a clipped flag.
// Configuration is written through cfg_we/cfg_index/cfg_wdata while no
// request is in flight.
// After reset and after every configuration write, a sequencer computes
// the ground extents and steps on one shared multiplier and one shared
// divider, and in_ready stays low while it runs. Once done, one request
// is taken every cycle while the output is not stalled; the 64-bit
// quotient dividers, one quotient bit per stage, set most of the
// pipeline depth.
// When the receiver stalls, the result stays in the output register and
// the pipeline keeps advancing as long as its last stage is empty, then
// holds in place; nothing is dropped or repeated.
// Reset is synchronous and active low; registers return to the default
// camera setup.
module tilt_perspective_remap_coords
  import tpr_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_t              in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_t             out_data,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  logic [31:0] cos_r, sin_r;
  logic [47:0] focal_r, height_r, sw_r, sh_r;
  logic [12:0] iw_r, ih_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_r    <= COS_TILT_RST;
      sin_r    <= SIN_TILT_RST;
      focal_r  <= FOCAL_LENGTH_RST;
      height_r <= MOUNT_HEIGHT_RST;
      sw_r     <= SENSOR_WIDTH_RST;
      sh_r     <= SENSOR_HEIGHT_RST;
      iw_r     <= IMAGE_WIDTH_RST;
      ih_r     <= IMAGE_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_COS_TILT:      cos_r    <= cfg_wdata[31:0];
        REG_SIN_TILT:      sin_r    <= cfg_wdata[31:0];
        REG_FOCAL_LENGTH:  focal_r  <= cfg_wdata;
        REG_MOUNT_HEIGHT:  height_r <= cfg_wdata;
        REG_SENSOR_WIDTH:  sw_r     <= cfg_wdata;
        REG_SENSOR_HEIGHT: sh_r     <= cfg_wdata;
        REG_IMAGE_WIDTH:   iw_r     <= cfg_wdata[12:0];
        REG_IMAGE_HEIGHT:  ih_r     <= cfg_wdata[12:0];
        default:           cos_r    <= cos_r;
      endcase
    end
  end

  logic [12:0] wcl, hcl;
  assign wcl = ({19'd0, iw_r} > 32'(MAX_WIDTH))  ? 13'(MAX_WIDTH)  : iw_r;
  assign hcl = ({19'd0, ih_r} > 32'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : ih_r;

  rnum_t c_n, s_n, f_n, h_n, ws_n, hs_n, wi_n, hi_n;
  assign c_n  = from_trig(cos_r);
  assign s_n  = from_trig(sin_r);
  assign f_n  = mk(1'b0, {16'd0, focal_r});
  assign h_n  = mk(1'b0, {16'd0, height_r});
  assign ws_n = mk(1'b0, {16'd0, sw_r});
  assign hs_n = mk(1'b0, {16'd0, sh_r});
  assign wi_n = from_int13(wcl);
  assign hi_n = from_int13(hcl);

  derived_t drv;
  logic     su_busy;

  tpr_setup u_setup (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cfg_we),
    .c     (c_n),
    .s     (s_n),
    .f     (f_n),
    .h     (h_n),
    .ws    (ws_n),
    .hs    (hs_n),
    .wi    (wi_n),
    .hi    (hi_n),
    .drv   (drv),
    .busy  (su_busy)
  );

  // Global advance: the pipeline moves unless its last stage is full and
  // the output register cannot drain.
  logic v7_r, out_valid_r, en;
  assign en       = !v7_r || !out_valid_r || out_ready;
  assign in_ready = en && !su_busy;

  // Stage 1: step times pixel index.
  logic  m1_v, m1y_sat, m1x_sat;
  rnum_t m1y_p, m1x_p;

  tpr_mul #(.SB_W(1)) u_m1y (
    .clk(clk), .rst_n(rst_n), .en(en), .vin(in_valid && in_ready),
    .a(drv.ystep), .b(from_int12(in_data.pixel_y)), .sbin(1'b0),
    .vout(m1_v), .p(m1y_p), .sat(m1y_sat), .sbout()
  );

  tpr_mul #(.SB_W(1)) u_m1x (
    .clk(clk), .rst_n(rst_n), .en(en), .vin(in_valid && in_ready),
    .a(drv.xstep), .b(from_int12(in_data.pixel_x)), .sbin(1'b0),
    .vout(), .p(m1x_p), .sat(m1x_sat), .sbout()
  );

  // Stage 2: ground coordinates.
  logic  v2_r, f2_r;
  rnum_t yr_r, xr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= m1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      yr_r <= radd(m1y_p, drv.yrmin);
      xr_r <= radd(m1x_p, drv.xrmin);
      f2_r <= m1y_sat | m1x_sat | radd_sat(m1y_p, drv.yrmin)
            | radd_sat(m1x_p, drv.xrmin);
    end
  end

  // Stage 3: s*yr, A*yr and F*WI*xr.
  logic  m3_v, t_sat, ay_sat, xn_sat, f3;
  rnum_t t_p, ay_p, xn_p;

  tpr_mul #(.SB_W(1)) u_m3t (
    .clk(clk), .rst_n(rst_n), .en(en), .vin(v2_r),
    .a(s_n), .b(yr_r), .sbin(f2_r),
    .vout(m3_v), .p(t_p), .sat(t_sat), .sbout(f3)
  );

  tpr_mul #(.SB_W(1)) u_m3a (
    .clk(clk), .rst_n(rst_n), .en(en), .vin(v2_r),
    .a(drv.a), .b(yr_r), .sbin(1'b0),
    .vout(), .p(ay_p), .sat(ay_sat), .sbout()
  );

  tpr_mul #(.SB_W(1)) u_m3x (
    .clk(clk), .rst_n(rst_n), .en(en), .vin(v2_r),
    .a(drv.fwi), .b(xr_r), .sbin(1'b0),
    .vout(), .p(xn_p), .sat(xn_sat), .sbout()
  );

  // Stage 4: depth Z.
  logic  v4_r, f4_r;
  rnum_t z_r, ay_r, xn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= m3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z_r  <= radd(drv.hc, rneg(t_p));
      ay_r <= ay_p;
      xn_r <= xn_p;
      f4_r <= f3 | t_sat | ay_sat | xn_sat | radd_sat(drv.hc, rneg(t_p));
    end
  end

  // Stage 5: numerator of the row and both divisors.
  logic        m5_v, yn_sat, dy_sat, dx_sat;
  rnum_t       yn_p, dy_p, dx_p, xn5;
  logic [65:0] sb5;
  logic        f5;

  tpr_mul #(.SB_W(66)) u_m5y (
    .clk(clk), .rst_n(rst_n), .en(en), .vin(v4_r),
    .a(ay_r), .b(hi_n), .sbin({f4_r, xn_r}),
    .vout(m5_v), .p(yn_p), .sat(yn_sat), .sbout(sb5)
  );

  tpr_mul #(.SB_W(1)) u_m5dy (
    .clk(clk), .rst_n(rst_n), .en(en), .vin(v4_r),
    .a(hs_n), .b(z_r), .sbin(1'b0),
    .vout(), .p(dy_p), .sat(dy_sat), .sbout()
  );

  tpr_mul #(.SB_W(1)) u_m5dx (
    .clk(clk), .rst_n(rst_n), .en(en), .vin(v4_r),
    .a(ws_n), .b(z_r), .sbin(1'b0),
    .vout(), .p(dx_p), .sat(dx_sat), .sbout()
  );

  assign xn5 = sb5[64:0];
  assign f5  = sb5[65] | yn_sat | dy_sat | dx_sat;

  // Stage 6: the two divisions.
  logic  d6_v, qy_sat, qx_sat, qy_zero, qx_zero, f6;
  rnum_t qy, qx;

  tpr_div #(.SB_W(1)) u_dy (
    .clk(clk), .rst_n(rst_n), .en(en), .vin(m5_v),
    .a(yn_p), .b(dy_p), .sbin(f5),
    .vout(d6_v), .q(qy), .sat(qy_sat), .zero(qy_zero), .sbout(f6)
  );

  tpr_div #(.SB_W(1)) u_dx (
    .clk(clk), .rst_n(rst_n), .en(en), .vin(m5_v),
    .a(xn5), .b(dx_p), .sbin(1'b0),
    .vout(), .q(qx), .sat(qx_sat), .zero(qx_zero), .sbout()
  );

  // Stage 7: add the image center.
  logic  sat7_r, zero7_r;
  rnum_t sy_r, sx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else if (en) begin
      v7_r <= d6_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sy_r    <= radd(rhalf(hi_n), qy);
      sx_r    <= radd(rhalf(wi_n), qx);
      sat7_r  <= f6 | qy_sat | qx_sat | radd_sat(rhalf(hi_n), qy)
               | radd_sat(rhalf(wi_n), qx);
      zero7_r <= qy_zero | qx_zero;
    end
  end

  // Output register.
  out_t out_r;
  logic zero_all;
  assign zero_all = zero7_r | drv.zero;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en && v7_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && v7_r) begin
      out_r.source_x <= zero_all ? 16'sd0 : to_out_val(sx_r);
      out_r.source_y <= zero_all ? 16'sd0 : to_out_val(sy_r);
      out_r.clipped  <= zero_all | sat7_r | drv.sat
                      | to_out_sat(sx_r) | to_out_sat(sy_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // A configuration write restarts the setup sequence and blocks input.
  a_cfg_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_ready)
    else $error("input accepted right after a configuration write");

  // A full last stage with a stalled output must hold its contents.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v7_r && out_valid_r && !out_ready) |=>
      (v7_r && $stable(sx_r) && $stable(sy_r)))
    else $error("last stage changed during an output stall");

  // A result moving out of the last stage lands in the output register.
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (en && v7_r) |=> out_valid_r)
    else $error("result lost between last stage and output register");

endmodule

[tb/sv/tilt_perspective_remap_coords_test.sv]
module tilt_perspective_remap_coords_test;
  import tpr_pkg::*;

  localparam int MAX_W = 4096;
  localparam int MAX_H = 4096;
  localparam int CYCLE_LIMIT = 600000;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_t              in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_t             out_data;
  logic             cfg_we = 1'b0;
  logic [2:0]       cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  tilt_perspective_remap_coords dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  // Shadow copy of the camera setup.
  logic [31:0] cam_cos, cam_sin;
  logic [47:0] cam_f, cam_h, cam_ws, cam_hs;
  logic [12:0] cam_wi, cam_hi;

  in_t   pending_px[$];
  out_t  expected_src[$];
  int    mismatches = 0;
  int    cycles = 0;
  bit    req_taken = 1'b0;
  int    burst_left = 0;
  int    gap_left = 0;
  int    stall_mode = 0;
  bit    ovf, divz;

  function automatic rnum_t num(input logic neg, input logic [63:0] mag);
    rnum_t r;
    r.neg = neg && (mag != 64'd0);
    r.mag = mag;
    return r;
  endfunction

  function automatic rnum_t negate(input rnum_t a);
    return num(!a.neg, a.mag);
  endfunction

  function automatic rnum_t halve(input rnum_t a);
    return num(a.neg, a.mag >> 1);
  endfunction

  function automatic rnum_t sum(input rnum_t a, input rnum_t b);
    logic [64:0] t;
    if (a.neg == b.neg) begin
      t = {1'b0, a.mag} + {1'b0, b.mag};
      if (t[64]) begin
        ovf = 1'b1;
        return num(a.neg, '1);
      end
      return num(a.neg, t[63:0]);
    end
    if (a.mag >= b.mag) return num(a.neg, a.mag - b.mag);
    return num(b.neg, b.mag - a.mag);
  endfunction

  function automatic rnum_t prod(input rnum_t a, input rnum_t b);
    logic [127:0] p;
    p = {64'd0, a.mag} * {64'd0, b.mag};
    if (p[127:96] != 0) begin
      ovf = 1'b1;
      return num(a.neg != b.neg, '1);
    end
    return num(a.neg != b.neg, p[95:32]);
  endfunction

  function automatic rnum_t quot(input rnum_t a, input rnum_t b);
    logic [127:0] n, q;
    if (b.mag == 0) begin
      divz = 1'b1;
      return num(1'b0, 64'd0);
    end
    if (a.mag[63:32] >= b.mag) begin
      ovf = 1'b1;
      return num(a.neg != b.neg, '1);
    end
    n = {32'd0, a.mag, 32'd0};
    q = n / {64'd0, b.mag};
    return num(a.neg != b.neg, q[63:0]);
  endfunction

  function automatic rnum_t q30(input logic [31:0] v);
    logic [31:0] m;
    m = v[31] ? (~v + 32'd1) : v;
    return num(v[31], {30'd0, m, 2'b00});
  endfunction

  function automatic rnum_t whole(input int unsigned n);
    return num(1'b0, {32'(n), 32'd0});
  endfunction

  function automatic logic [15:0] saturate16(input rnum_t v);
    logic [31:0] ip;
    ip = v.mag[63:32];
    if (v.neg) begin
      if (ip > 32'd32768) begin
        ovf = 1'b1;
        ip = 32'd32768;
      end
      return 16'(32'h10000 - ip);
    end
    if (ip > 32'd32767) begin
      ovf = 1'b1;
      ip = 32'd32767;
    end
    return ip[15:0];
  endfunction

  function automatic out_t remap_pixel(input in_t px);
    int unsigned w, h;
    rnum_t c, s, f, hm, ws, hs, wi, hi, hc, a, shalf, num0;
    rnum_t yrmax, yrmin, z0, xrmax, xrmin, ystep, xstep, yr, xr, z, sy, sx;
    out_t r;
    ovf = 1'b0;
    divz = 1'b0;
    w = (cam_wi > MAX_W) ? MAX_W : cam_wi;
    h = (cam_hi > MAX_H) ? MAX_H : cam_hi;
    c = q30(cam_cos);
    s = q30(cam_sin);
    f = num(1'b0, {16'd0, cam_f});
    hm = num(1'b0, {16'd0, cam_h});
    ws = num(1'b0, {16'd0, cam_ws});
    hs = num(1'b0, {16'd0, cam_hs});
    wi = whole(w);
    hi = whole(h);
    hc = quot(hm, c);
    a = prod(f, c);
    shalf = halve(prod(s, hs));
    num0 = prod(halve(hs), hc);
    yrmax = quot(num0, sum(a, shalf));
    yrmin = negate(quot(num0, sum(a, negate(shalf))));
    z0 = sum(hc, negate(prod(s, yrmin)));
    xrmax = halve(quot(prod(z0, ws), f));
    xrmin = negate(xrmax);
    ystep = quot(sum(sum(yrmax, negate(yrmin)), whole(1)), hi);
    xstep = quot(sum(sum(xrmax, negate(xrmin)), whole(1)), wi);
    yr = sum(prod(ystep, whole(px.pixel_y)), yrmin);
    xr = sum(prod(xstep, whole(px.pixel_x)), xrmin);
    z = sum(hc, negate(prod(s, yr)));
    sy = sum(halve(hi), quot(prod(prod(a, yr), hi), prod(hs, z)));
    sx = sum(halve(wi), quot(prod(prod(f, wi), xr), prod(ws, z)));
    if (divz) begin
      r.source_x = '0;
      r.source_y = '0;
    end else begin
      r.source_x = saturate16(sx);
      r.source_y = saturate16(sy);
    end
    r.clipped = divz | ovf;
    return r;
  endfunction

  // Request side: bursts of back-to-back requests, separated by idle gaps that are sometimes empty.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || req_taken)) begin
      if (gap_left > 0 || pending_px.size() == 0) begin
        in_valid <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end else begin
        in_valid <= 1'b1;
        in_data <= pending_px.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Result side: the stall pattern is redrawn at random from four modes.
  always @(negedge clk) begin
    if (cycles % 64 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ((cycles % 16) < 4);
      default: out_ready <= ($urandom_range(0, 1) == 1);
    endcase
  end

  always @(posedge clk) begin
    out_t got, want;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[tilt_perspective_remap_coords] ERROR");
      $finish;
    end
    req_taken <= in_valid && in_ready;
    if (rst_n && in_valid && in_ready) expected_src.push_back(remap_pixel(in_data));
    if (rst_n && out_valid && out_ready) begin
      got = out_data;
      if (expected_src.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = expected_src.pop_front();
        if (got.source_x !== want.source_x || got.source_y !== want.source_y ||
            got.clipped !== want.clipped) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  task automatic write_reg(input cfg_reg_t r, input logic [47:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= v;
    case (r)
      REG_COS_TILT:      cam_cos = v[31:0];
      REG_SIN_TILT:      cam_sin = v[31:0];
      REG_FOCAL_LENGTH:  cam_f = v;
      REG_MOUNT_HEIGHT:  cam_h = v;
      REG_SENSOR_WIDTH:  cam_ws = v;
      REG_SENSOR_HEIGHT: cam_hs = v;
      REG_IMAGE_WIDTH:   cam_wi = v[12:0];
      default:           cam_hi = v[12:0];
    endcase
  endtask

  task automatic set_camera(input logic [31:0] c, input logic [31:0] s,
                            input logic [47:0] f, input logic [47:0] h,
                            input logic [47:0] ws, input logic [47:0] hs,
                            input logic [12:0] wi, input logic [12:0] hi);
    write_reg(REG_COS_TILT, {16'd0, c});
    write_reg(REG_SIN_TILT, {16'd0, s});
    write_reg(REG_FOCAL_LENGTH, f);
    write_reg(REG_MOUNT_HEIGHT, h);
    write_reg(REG_SENSOR_WIDTH, ws);
    write_reg(REG_SENSOR_HEIGHT, hs);
    write_reg(REG_IMAGE_WIDTH, {35'd0, wi});
    write_reg(REG_IMAGE_HEIGHT, {35'd0, hi});
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_px(input int x, input int y);
    in_t p;
    p.pixel_x = x[11:0];
    p.pixel_y = y[11:0];
    pending_px.push_back(p);
  endtask

  // Mostly pixels inside the image, some anywhere in the field range.
  task automatic push_random(input int n);
    int w, h;
    w = (cam_wi > MAX_W) ? MAX_W : ((cam_wi == 0) ? 1 : cam_wi);
    h = (cam_hi > MAX_H) ? MAX_H : ((cam_hi == 0) ? 1 : cam_hi);
    repeat (n) begin
      if ($urandom_range(0, 9) < 7) push_px($urandom_range(0, w - 1), $urandom_range(0, h - 1));
      else push_px($urandom_range(0, 4095), $urandom_range(0, 4095));
    end
  endtask

  task automatic drain;
    wait (pending_px.size() == 0 && !in_valid && expected_src.size() == 0);
    repeat (100) @(negedge clk);
  endtask

  function automatic logic [47:0] rand48;
    return {16'($urandom), $urandom};
  endfunction

  initial begin
    cam_cos = COS_TILT_RST;
    cam_sin = SIN_TILT_RST;
    cam_f = FOCAL_LENGTH_RST;
    cam_h = MOUNT_HEIGHT_RST;
    cam_ws = SENSOR_WIDTH_RST;
    cam_hs = SENSOR_HEIGHT_RST;
    cam_wi = IMAGE_WIDTH_RST;
    cam_hi = IMAGE_HEIGHT_RST;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Default camera: corners, center and pixels beyond the image.
    push_px(0, 0);
    push_px(4095, 4095);
    push_px(0, 4095);
    push_px(4095, 0);
    push_px(960, 540);
    push_px(1919, 1079);
    push_px(2048, 2048);
    push_random(50);
    drain();

    // Realistic tilt, about 20 degrees.
    set_camera(32'h3C1B_F1E0, 32'h15E2_144A, FOCAL_LENGTH_RST, MOUNT_HEIGHT_RST,
               SENSOR_WIDTH_RST, SENSOR_HEIGHT_RST, 13'd640, 13'd480);
    push_random(50);
    drain();

    // Small image, so many requests extrapolate outside it.
    set_camera(32'h3F00_0000, 32'hF000_0000, 48'd40000000, 48'h0010_0000_0000,
               48'd30000000, 48'd20000000, 13'd16, 13'd1);
    push_px(15, 0);
    push_px(16, 1);
    push_px(4095, 4095);
    push_random(30);
    drain();

    // Zero cosine makes every divisor chain collapse.
    set_camera(32'h0000_0000, 32'h4000_0000, FOCAL_LENGTH_RST, MOUNT_HEIGHT_RST,
               SENSOR_WIDTH_RST, SENSOR_HEIGHT_RST, 13'd1920, 13'd1080);
    push_px(0, 0);
    push_random(15);
    drain();

    // Register extremes and oversized image.
    set_camera(32'h7FFF_FFFF, 32'h8000_0000, 48'd1, 48'hFFFF_FFFF_FFFF,
               48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 13'h1FFF, 13'h1FFF);
    push_px(0, 0);
    push_px(4095, 4095);
    push_random(20);
    drain();

    set_camera(32'h8000_0000, 32'h7FFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'd1,
               48'd1, 48'd1, 13'd4096, 13'd4096);
    push_random(20);
    drain();

    // Random cameras near plausible values, then fully random ones.
    for (int k = 0; k < 8; k++) begin
      if (k < 5)
        set_camera(32'h3000_0000 + $urandom_range(0, 32'h0FFF_FFFF),
                   $urandom_range(0, 32'h1FFF_FFFF) ^ ($urandom_range(0, 1) ? '1 : '0),
                   48'($urandom_range(1000000, 80000000)),
                   {16'($urandom_range(1, 2000)), $urandom},
                   48'($urandom_range(1000000, 80000000)),
                   48'($urandom_range(1000000, 80000000)),
                   13'($urandom_range(16, 2048)), 13'($urandom_range(16, 2048)));
      else
        set_camera($urandom, $urandom, rand48() | 48'd1, rand48() | 48'd1,
                   rand48() | 48'd1, rand48() | 48'd1,
                   13'($urandom_range(1, 8191)), 13'($urandom_range(1, 8191)));
      push_random(25);
      drain();
    end

    if (mismatches == 0) begin
      $display("[tilt_perspective_remap_coords] OK");
    end else begin
      $display("[tilt_perspective_remap_coords] ERROR");
    end
    $finish;
  end

endmodule
